// ===== hw/rtl/eprm_pkg.sv =====
// Shared types and constants of the echo pulse range meter.
`timescale 1ns / 1ps
package eprm_pkg;

  // Field and register widths
  localparam int unsigned CNT_W   = 16;  // capture counter
  localparam int unsigned HZ_W    = 27;  // timer frequency register
  localparam int unsigned DIST_W  = 10;  // distance in cm
  localparam int unsigned ST_W    = 2;   // status code
  localparam int unsigned MODE_W  = 2;   // item kind
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_W   = 16;  // result tdata, whole bytes

  // Tick to microsecond scaling
  localparam int unsigned SCALE_W = 20;
  localparam logic [SCALE_W-1:0] US_PER_S = SCALE_W'(1000000);
  localparam int unsigned PROD_W  = CNT_W + SCALE_W;
  localparam int unsigned REM_W   = HZ_W + 1;

  // Microseconds to centimeters: cm = (us + 29) / 58
  localparam int unsigned CM_DIVISOR = 58;
  localparam int unsigned CM_ROUND   = 29;
  localparam int unsigned LIMIT_W    = 16;  // max_distance_cm * 58 fits here

  // Reset values of the registers
  localparam logic [HZ_W-1:0]   HZ_RST     = HZ_W'(1000000);
  localparam logic [CNT_W-1:0]  RELOAD_RST = CNT_W'(65535);
  localparam logic [DIST_W-1:0] MAXD_RST   = DIST_W'(400);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_HZ  = 2'd0,
    CFG_RELOAD    = 2'd1,
    CFG_MAX_DIST  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_START   = 2'd0,
    MODE_EDGE    = 2'd1,
    MODE_READ    = 2'd2,
    MODE_IGNORE  = 2'd3
  } mode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BUSY      = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'b001,
    PH_WAIT_RISE = 3'b010,
    PH_WAIT_FALL = 3'b100
  } phase_e;

  // Request to the shared serial divider
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [HZ_W-1:0]   divisor;
  } div_req_t;

  // One result item
  typedef struct packed {
    logic              arm_falling;
    logic              trigger_request;
    logic [DIST_W-1:0] distance_cm;
    status_e           status;
  } result_t;

endpackage

// ===== hw/rtl/eprm_mul.sv =====
// Bit-serial multiplier: pulse width in ticks times one million.
`timescale 1ns / 1ps
module eprm_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [eprm_pkg::CNT_W-1:0] ticks_i,
  output logic [eprm_pkg::PROD_W-1:0] prod_o,
  output logic                       done_o
);
  import eprm_pkg::*;

  localparam int unsigned STEP_W = $clog2(CNT_W + 1);

  logic [CNT_W-1:0]  sh_q, sh_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  // Consume one multiplier bit per cycle, MSB first
  always_comb begin
    sh_d   = sh_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = ticks_i;
      acc_d  = '0;
      cnt_d  = STEP_W'(CNT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[PROD_W-2:0], 1'b0}
            + (sh_q[CNT_W-1] ? PROD_W'(US_PER_S) : PROD_W'(0));
      sh_d  = {sh_q[CNT_W-2:0], 1'b0};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/eprm_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module eprm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  eprm_pkg::div_req_t          req_i,
  output logic [eprm_pkg::PROD_W-1:0] quot_o,
  output logic                        done_o
);
  import eprm_pkg::*;

  localparam int unsigned STEP_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [HZ_W-1:0]   dvs_q, dvs_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [REM_W-1:0]  trial;

  // Shift dividend out of the top, quotient bits in at the bottom
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[REM_W-2:0], quo_q[PROD_W-1]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = STEP_W'(PROD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[PROD_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[PROD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/echo_pulse_range_meter_core.sv =====
// Top level of the ultrasonic echo pulse range meter.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata: capture_time; tuser: mode
//  m_axis   | out       | m_axis_tvalid/tready    | tdata: status, distance_cm, trig, arm
//  cfg      | in        | cfg_we_i                | cfg_idx_i selects, cfg_data_i value
//
// Immediate results reach m_axis through the pending register, then the output register;
// no new item is taken while a result is pending. A read of a valid measurement runs the
// multiplier, rate divider, clamp, divide by 58 and output staging; past the ceiling, no divide.
// Reset returns the phase to idle, sets the last status to not-ready and clears all handshake state.
// A stalled m_axis holds the output register, then the pending register, then drops
// s_axis_tready; one item may still be accepted while a result waits on m_axis.
`timescale 1ns / 1ps
module echo_pulse_range_meter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [eprm_pkg::CNT_W-1:0]    s_axis_tdata,  // [15:0] capture_time
  input  logic [eprm_pkg::MODE_W-1:0]   s_axis_tuser,  // [1:0] mode
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] status, [11:2] distance_cm, [12] trigger_request, [13] arm_falling
  output logic [eprm_pkg::OUT_W-1:0]    m_axis_tdata,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [eprm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [eprm_pkg::HZ_W-1:0]     cfg_data_i
);
  import eprm_pkg::*;

  typedef enum logic [4:0] {
    SQ_IDLE   = 5'b00001,
    SQ_MUL    = 5'b00010,
    SQ_DIV_US = 5'b00100,
    SQ_CLAMP  = 5'b01000,
    SQ_DIV_CM = 5'b10000
  } seq_e;

  localparam int unsigned RES_W = $bits(result_t);

  // Configuration
  logic [HZ_W-1:0]   timer_hz_q;
  logic [CNT_W-1:0]  reload_q;
  logic [DIST_W-1:0] max_dist_q;

  // Measurement state
  phase_e           phase_q, phase_d;
  status_e          last_q, last_d;
  logic [CNT_W-1:0] rise_q, rise_d;
  logic [CNT_W-1:0] fall_q, fall_d;
  seq_e             seq_q, seq_d;

  // Result path
  logic          pend_valid_q, pend_valid_d;
  result_t       pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  result_t       out_q, out_d;

  logic          accept;
  mode_e         mode;
  logic          go_calc;
  logic          imm_valid;
  result_t       imm_res;
  logic          calc_valid;
  result_t       calc_res;
  logic          out_load;

  logic [CNT_W-1:0]   ticks;
  logic [HZ_W-1:0]    hz_eff;
  logic [LIMIT_W-1:0] limit;
  logic [CNT_W:0]     round_sum;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_prod;
  div_req_t           div_req;
  logic [PROD_W-1:0]  div_quot;
  logic               div_done;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign mode   = mode_e'(s_axis_tuser);

  // Hold new items off while the sequencer runs or a result is pending
  assign s_axis_tready = (seq_q == SQ_IDLE) && !pend_valid_q;

  // Configuration writes; index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_hz_q <= HZ_RST;
      reload_q   <= RELOAD_RST;
      max_dist_q <= MAXD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMER_HZ: timer_hz_q <= cfg_data_i;
        CFG_RELOAD:   reload_q   <= cfg_data_i[CNT_W-1:0];
        CFG_MAX_DIST: max_dist_q <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Pulse width with one counter rollover, modulo the counter range
  always_comb begin
    if (fall_q >= rise_q) begin
      ticks = fall_q - rise_q;
    end else begin
      ticks = reload_q + CNT_W'(1) + fall_q - rise_q;
    end
  end

  assign hz_eff    = (timer_hz_q == '0) ? HZ_W'(1) : timer_hz_q;
  assign limit     = LIMIT_W'(max_dist_q) * LIMIT_W'(CM_DIVISOR);
  assign round_sum = {1'b0, div_quot[CNT_W-1:0]} + (CNT_W+1)'(CM_ROUND);

  // Item decode: state update and the immediate result
  always_comb begin
    phase_d   = phase_q;
    last_d    = last_q;
    rise_d    = rise_q;
    fall_d    = fall_q;
    go_calc   = 1'b0;
    imm_res   = '{arm_falling: 1'b0, trigger_request: 1'b0,
                  distance_cm: '0, status: ST_OK};
    if (accept) begin
      case (mode)
        MODE_START: begin
          if (phase_q != PH_IDLE) begin
            imm_res.status = ST_BUSY;
          end else begin
            last_d  = ST_NOT_READY;
            phase_d = PH_WAIT_RISE;
            imm_res.trigger_request = 1'b1;
          end
        end
        MODE_EDGE: begin
          if (phase_q == PH_WAIT_RISE) begin
            rise_d  = s_axis_tdata;
            phase_d = PH_WAIT_FALL;
          end else if (phase_q == PH_WAIT_FALL) begin
            fall_d  = s_axis_tdata;
            phase_d = PH_IDLE;
            last_d  = ST_OK;
          end
        end
        MODE_READ: begin
          if (phase_q != PH_IDLE) begin
            // read during a measurement ends it as a timeout
            phase_d = PH_IDLE;
            last_d  = ST_TIMEOUT;
            imm_res.status      = ST_TIMEOUT;
            imm_res.distance_cm = max_dist_q;
          end else if (last_q == ST_OK) begin
            go_calc = 1'b1;
          end else begin
            imm_res.status = last_q;
          end
        end
        default: ;
      endcase
      imm_res.arm_falling = (phase_d == PH_WAIT_FALL);
    end
  end

  assign imm_valid = accept && !go_calc;

  // Distance sequencer: multiply, divide by rate, then clamp or divide by 58
  always_comb begin
    seq_d      = seq_q;
    calc_valid = 1'b0;
    calc_res   = '{arm_falling: 1'b0, trigger_request: 1'b0,
                   distance_cm: '0, status: ST_OK};
    div_req    = '{start: 1'b0, dividend: '0, divisor: '0};
    case (seq_q)
      SQ_IDLE: begin
        if (go_calc) begin
          seq_d = SQ_MUL;
        end
      end
      SQ_MUL: begin
        if (mul_done) begin
          div_req = '{start: 1'b1, dividend: mul_prod, divisor: hz_eff};
          seq_d   = SQ_DIV_US;
        end
      end
      SQ_DIV_US: begin
        if (div_done) begin
          seq_d = SQ_CLAMP;
        end
      end
      SQ_CLAMP: begin
        if (div_quot > PROD_W'(limit)) begin
          calc_valid = 1'b1;
          calc_res.distance_cm = max_dist_q;
          seq_d = SQ_IDLE;
        end else begin
          div_req = '{start: 1'b1, dividend: PROD_W'(round_sum),
                      divisor: HZ_W'(CM_DIVISOR)};
          seq_d   = SQ_DIV_CM;
        end
      end
      SQ_DIV_CM: begin
        if (div_done) begin
          calc_valid = 1'b1;
          calc_res.distance_cm = div_quot[DIST_W-1:0];
          seq_d = SQ_IDLE;
        end
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  eprm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_calc),
    .ticks_i (ticks),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  eprm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .quot_o (div_quot),
    .done_o (div_done)
  );

  // Pending stage feeds the output register whenever that slot frees up
  assign out_load = pend_valid_q && (!out_valid_q || m_axis_tready);

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      pend_valid_d = 1'b0;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (imm_valid) begin
      pend_valid_d = 1'b1;
      pend_d       = imm_res;
    end else if (calc_valid) begin
      pend_valid_d = 1'b1;
      pend_d       = calc_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      last_q       <= ST_NOT_READY;
      seq_q        <= SQ_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      last_q       <= last_d;
      seq_q        <= seq_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Edge times and result payloads need no reset
  always_ff @(posedge clk_i) begin
    rise_q <= rise_d;
    fall_q <= fall_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_W-RES_W)'(0), out_q};

endmodule
